// ----- rtl/core/strc_pkg.sv -----
`default_nettype none

package strc_pkg;

   // color channel geometry
   localparam int CHAN_W = 8;
   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;
   localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'h00;

   // quotient bits of the ramp divider, one per pipeline stage
   localparam int QUOT_W = 8;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_LOW   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_HIGH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIGNED_MODE = 2'd2;

   // how the final color is built from the ramp value
   typedef enum logic [3:0] {
      KIND_BLUE,
      KIND_RED,
      KIND_GREEN,
      KIND_SEG0,
      KIND_SEG1,
      KIND_SEG2,
      KIND_SEG3,
      KIND_SNEG,
      KIND_SPOS
   } kind_type;

endpackage

`default_nettype wire

// ----- rtl/core/scalar_to_rainbow_color.sv -----
// Rainbow pseudocolor for a stream of signed Q8.8 samples. Each word on the req_ side
// carries one sample and yields one RGB word on the rsp_ side, in order. Unsigned mode
// ramps blue, cyan, green, yellow, red across the four quarters of the configured range
// (blue below, red above); signed mode fades red for negative and blue for positive
// samples against green. The block takes one word per clock unless a low rsp_tready
// has backed the pipeline up to its input. The depth comes from the 255*num/den ramp
// division, a restoring divider that resolves one quotient bit per pipeline stage over
// eight stages. Five stages of range and segment arithmetic and one operand stage sit in
// front of it, and the output register follows, for fifteen register stages in all.
// Each stage advances on its own, so empty stages fill while the output waits.
// Write the csr_ registers only while the pipeline is empty.
`default_nettype none

module scalar_to_rainbow_color
   import strc_pkg::*;
#(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration write port
   input  logic                               csr_wen,
   input  logic [CSR_IDX_W-1:0]               csr_index,
   input  logic [VALUE_WIDTH-1:0]             csr_wdata,
   // sample stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [((VALUE_WIDTH+7)/8)*8-1:0]   req_tdata,   // [VALUE_WIDTH-1:0] sample_value
   // color stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [3*CHAN_W-1:0]                rsp_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

   localparam int W        = VALUE_WIDTH;
   localparam int NW       = VALUE_WIDTH + QUOT_W;
   localparam int ST_IN    = 0;
   localparam int ST_D     = 1;
   localparam int ST_Q     = 2;
   localparam int ST_CMP   = 3;
   localparam int ST_SEL   = 4;
   localparam int ST_NUM   = 5;
   localparam int ST_DIV0  = 6;
   localparam int ST_DLAST = ST_DIV0 + QUOT_W - 1;
   localparam int ST_OUT   = ST_DLAST + 1;
   localparam int NSTG     = ST_OUT + 1;

   // configuration registers
   logic signed [W-1:0] csr_low_ff;
   logic signed [W-1:0] csr_high_ff;
   logic                csr_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_low_ff  <= '0;
         csr_high_ff <= W'(256);
         csr_mode_ff <= 1'b0;
      end else if (csr_wen) begin
         case (csr_index)
            REG_RANGE_LOW:   csr_low_ff  <= csr_wdata;
            REG_RANGE_HIGH:  csr_high_ff <= csr_wdata;
            REG_SIGNED_MODE: csr_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // stage valids and per-stage advance (a stage moves when empty or when the next moves)
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_prev;
   logic [NSTG:0]   adv;

   assign vld_prev = {vld_ff[NSTG-2:0], req_tvalid};

   always_comb begin
      adv[NSTG] = rsp_tready;
      for (int s = NSTG - 1; s >= 0; s--) begin
         adv[s] = !vld_ff[s] || adv[s+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < NSTG; s++) begin
            if (adv[s]) begin
               vld_ff[s] <= vld_prev[s];
            end
         end
      end
   end

   assign req_tready = adv[ST_IN];
   assign rsp_tvalid = vld_ff[ST_OUT];

   // stage 1: capture sample, order the range bounds
   logic signed [W-1:0] lo_in, hi_in;
   logic signed [W-1:0] s1_v_ff, s1_lo_ff, s1_hi_ff;
   logic                s1_mode_ff;

   assign lo_in = (csr_low_ff > csr_high_ff) ? csr_high_ff : csr_low_ff;
   assign hi_in = (csr_low_ff > csr_high_ff) ? csr_low_ff : csr_high_ff;

   always_ff @(posedge clock) begin
      if (adv[ST_IN]) begin
         s1_v_ff    <= req_tdata[W-1:0];
         s1_lo_ff   <= lo_in;
         s1_hi_ff   <= hi_in;
         s1_mode_ff <= csr_mode_ff;
      end
   end

   // stage 2: range width, out-of-range flags, clamped sample
   logic [W-1:0]        d_in;
   logic                below_in, above_in;
   logic signed [W-1:0] vc_in;
   logic signed [W-1:0] s2_v_ff, s2_lo_ff, s2_hi_ff, s2_vc_ff;
   logic [W-1:0]        s2_d_ff;
   logic                s2_below_ff, s2_above_ff, s2_mode_ff;

   assign d_in     = W'(s1_hi_ff - s1_lo_ff);
   assign below_in = s1_v_ff < s1_lo_ff;
   assign above_in = s1_v_ff > s1_hi_ff;
   assign vc_in    = below_in ? s1_lo_ff : (above_in ? s1_hi_ff : s1_v_ff);

   always_ff @(posedge clock) begin
      if (adv[ST_D]) begin
         s2_v_ff     <= s1_v_ff;
         s2_lo_ff    <= s1_lo_ff;
         s2_hi_ff    <= s1_hi_ff;
         s2_d_ff     <= d_in;
         s2_below_ff <= below_in;
         s2_above_ff <= above_in;
         s2_vc_ff    <= vc_in;
         s2_mode_ff  <= s1_mode_ff;
      end
   end

   // stage 3: first two quarter points, 3/4 width, signed-mode operands
   logic signed [W-1:0] q1_in, q2_in;
   logic [W+1:0]        d3_sum;
   logic                sneg_in;
   logic [W-1:0]        snum_in, sden_in;
   logic signed [W-1:0] s3_v_ff, s3_lo_ff, s3_hi_ff, s3_q1_ff, s3_q2_ff;
   logic [W-1:0]        s3_d3_ff, s3_snum_ff, s3_sden_ff;
   logic                s3_below_ff, s3_above_ff, s3_empty_ff, s3_mode_ff, s3_sneg_ff;

   assign q1_in   = W'(s2_lo_ff + {2'b00, s2_d_ff[W-1:2]});
   assign q2_in   = W'(s2_lo_ff + {1'b0, s2_d_ff[W-1:1]});
   assign d3_sum  = {2'b00, s2_d_ff} + {1'b0, s2_d_ff, 1'b0};
   assign sneg_in = s2_vc_ff[W-1];
   assign snum_in = sneg_in ? W'(-s2_vc_ff) : s2_vc_ff;
   assign sden_in = sneg_in ? W'(-s2_lo_ff) : s2_hi_ff;

   always_ff @(posedge clock) begin
      if (adv[ST_Q]) begin
         s3_v_ff     <= s2_v_ff;
         s3_lo_ff    <= s2_lo_ff;
         s3_hi_ff    <= s2_hi_ff;
         s3_q1_ff    <= q1_in;
         s3_q2_ff    <= q2_in;
         s3_d3_ff    <= d3_sum[W+1:2];
         s3_below_ff <= s2_below_ff;
         s3_above_ff <= s2_above_ff;
         s3_empty_ff <= (s2_d_ff == '0);
         s3_mode_ff  <= s2_mode_ff;
         s3_sneg_ff  <= sneg_in;
         s3_snum_ff  <= snum_in;
         s3_sden_ff  <= sden_in;
      end
   end

   // stage 4: third quarter point, lower segment compares
   logic signed [W-1:0] q3_in;
   logic signed [W-1:0] s4_v_ff, s4_lo_ff, s4_hi_ff, s4_q1_ff, s4_q2_ff, s4_q3_ff;
   logic [W-1:0]        s4_snum_ff, s4_sden_ff;
   logic                s4_le1_ff, s4_le2_ff;
   logic                s4_below_ff, s4_above_ff, s4_empty_ff, s4_mode_ff, s4_sneg_ff;

   assign q3_in = W'(s3_lo_ff + s3_d3_ff);

   always_ff @(posedge clock) begin
      if (adv[ST_CMP]) begin
         s4_v_ff     <= s3_v_ff;
         s4_lo_ff    <= s3_lo_ff;
         s4_hi_ff    <= s3_hi_ff;
         s4_q1_ff    <= s3_q1_ff;
         s4_q2_ff    <= s3_q2_ff;
         s4_q3_ff    <= q3_in;
         s4_le1_ff   <= s3_v_ff <= s3_q1_ff;
         s4_le2_ff   <= s3_v_ff <= s3_q2_ff;
         s4_below_ff <= s3_below_ff;
         s4_above_ff <= s3_above_ff;
         s4_empty_ff <= s3_empty_ff;
         s4_mode_ff  <= s3_mode_ff;
         s4_sneg_ff  <= s3_sneg_ff;
         s4_snum_ff  <= s3_snum_ff;
         s4_sden_ff  <= s3_sden_ff;
      end
   end

   // stage 5: pick color kind and the ramp numerator and denominator
   logic         le3;
   kind_type     kind_in;
   logic [W-1:0] num_in, den_in;
   kind_type     s5_kind_ff;
   logic [W-1:0] s5_num_ff, s5_den_ff;

   always_comb begin
      le3     = s4_v_ff <= s4_q3_ff;
      kind_in = KIND_BLUE;
      num_in  = '0;
      den_in  = '0;
      if (!s4_mode_ff) begin
         if (s4_empty_ff || s4_below_ff) begin
            kind_in = KIND_BLUE;
         end else if (s4_above_ff) begin
            kind_in = KIND_RED;
         end else if (s4_le1_ff) begin
            kind_in = KIND_SEG0;
            num_in  = W'(s4_v_ff - s4_lo_ff);
            den_in  = W'(s4_q1_ff - s4_lo_ff);
         end else if (s4_le2_ff) begin
            kind_in = KIND_SEG1;
            num_in  = W'(s4_v_ff - s4_q1_ff);
            den_in  = W'(s4_q2_ff - s4_q1_ff);
         end else if (le3) begin
            kind_in = KIND_SEG2;
            num_in  = W'(s4_v_ff - s4_q2_ff);
            den_in  = W'(s4_q3_ff - s4_q2_ff);
         end else begin
            kind_in = KIND_SEG3;
            num_in  = W'(s4_v_ff - s4_q3_ff);
            den_in  = W'(s4_hi_ff - s4_q3_ff);
         end
      end else begin
         if (s4_empty_ff) begin
            kind_in = KIND_GREEN;
         end else begin
            kind_in = s4_sneg_ff ? KIND_SNEG : KIND_SPOS;
            num_in  = s4_snum_ff;
            den_in  = s4_sden_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_SEL]) begin
         s5_kind_ff <= kind_in;
         s5_num_ff  <= num_in;
         s5_den_ff  <= den_in;
      end
   end

   // stage 6: dividend 255*num; a zero divisor becomes 0/1 so the ramp reads zero
   logic          den_nz;
   logic [NW-1:0] rem0_in;
   logic [W-1:0]  den0_in;
   logic [NW-1:0] s6_rem_ff;
   logic [W-1:0]  s6_den_ff;
   kind_type      s6_kind_ff;

   assign den_nz  = s5_den_ff != '0;
   assign rem0_in = den_nz ? ({s5_num_ff, {QUOT_W{1'b0}}} - {{QUOT_W{1'b0}}, s5_num_ff}) : '0;
   assign den0_in = den_nz ? s5_den_ff : W'(1);

   always_ff @(posedge clock) begin
      if (adv[ST_NUM]) begin
         s6_rem_ff  <= rem0_in;
         s6_den_ff  <= den0_in;
         s6_kind_ff <= s5_kind_ff;
      end
   end

   // stages 7..14: restoring divider, one quotient bit per stage, MSB first
   logic [NW-1:0]     div_rem_ff  [QUOT_W];
   logic [W-1:0]      div_den_ff  [QUOT_W];
   logic [QUOT_W-1:0] div_quot_ff [QUOT_W];
   kind_type          div_kind_ff [QUOT_W];

   for (genvar j = 0; j < QUOT_W; j++) begin : g_div
      logic [NW-1:0]     rem_prev;
      logic [W-1:0]      den_prev;
      logic [QUOT_W-1:0] quot_prev;
      kind_type          kind_prev;
      logic [NW-1:0]     sub;
      logic [NW:0]       diff;
      logic              take;

      if (j == 0) begin : g_first
         assign rem_prev  = s6_rem_ff;
         assign den_prev  = s6_den_ff;
         assign quot_prev = '0;
         assign kind_prev = s6_kind_ff;
      end else begin : g_next
         assign rem_prev  = div_rem_ff[j-1];
         assign den_prev  = div_den_ff[j-1];
         assign quot_prev = div_quot_ff[j-1];
         assign kind_prev = div_kind_ff[j-1];
      end

      assign sub  = {{QUOT_W{1'b0}}, den_prev} << (QUOT_W - 1 - j);
      assign diff = {1'b0, rem_prev} - {1'b0, sub};
      assign take = !diff[NW];

      always_ff @(posedge clock) begin
         if (adv[ST_DIV0+j]) begin
            div_rem_ff[j]  <= take ? diff[NW-1:0] : rem_prev;
            div_den_ff[j]  <= den_prev;
            div_quot_ff[j] <= {quot_prev[QUOT_W-2:0], take};
            div_kind_ff[j] <= kind_prev;
         end
      end
   end

   // stage 15: build the color word
   logic [CHAN_W-1:0] u, u_inv;
   logic [CHAN_W-1:0] red_in, green_in, blue_in;
   logic [CHAN_W-1:0] red_ff, green_ff, blue_ff;

   assign u     = div_quot_ff[QUOT_W-1];
   assign u_inv = CHAN_MAX - u;

   always_comb begin
      case (div_kind_ff[QUOT_W-1])
         KIND_BLUE:  begin red_in = CHAN_ZERO; green_in = CHAN_ZERO; blue_in = CHAN_MAX;  end
         KIND_RED:   begin red_in = CHAN_MAX;  green_in = CHAN_ZERO; blue_in = CHAN_ZERO; end
         KIND_GREEN: begin red_in = CHAN_ZERO; green_in = CHAN_MAX;  blue_in = CHAN_ZERO; end
         KIND_SEG0:  begin red_in = CHAN_ZERO; green_in = u;         blue_in = CHAN_MAX;  end
         KIND_SEG1:  begin red_in = CHAN_ZERO; green_in = CHAN_MAX;  blue_in = u_inv;     end
         KIND_SEG2:  begin red_in = u;         green_in = CHAN_MAX;  blue_in = CHAN_ZERO; end
         KIND_SEG3:  begin red_in = CHAN_MAX;  green_in = u_inv;     blue_in = CHAN_ZERO; end
         KIND_SNEG:  begin red_in = u;         green_in = u_inv;     blue_in = CHAN_ZERO; end
         KIND_SPOS:  begin red_in = CHAN_ZERO; green_in = u_inv;     blue_in = u;         end
         default:    begin red_in = CHAN_ZERO; green_in = CHAN_ZERO; blue_in = CHAN_MAX;  end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[ST_OUT]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_tdata = {blue_ff, green_ff, red_ff};

   // an accepted word lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[ST_IN])
      else $error("accepted word did not enter the pipeline");

   // divisor entering the divider is never zero
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_NUM] |-> (s6_den_ff != '0))
      else $error("zero divisor reached the divider");

   // after the last step the remainder is below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_DLAST] |-> (div_rem_ff[QUOT_W-1] < {{QUOT_W{1'b0}}, div_den_ff[QUOT_W-1]}))
      else $error("divider remainder not reduced");

   // fixed colors carry a zero ramp value
   a_fixed_zero: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[ST_DLAST] && (div_kind_ff[QUOT_W-1] == KIND_BLUE ||
                            div_kind_ff[QUOT_W-1] == KIND_RED ||
                            div_kind_ff[QUOT_W-1] == KIND_GREEN))
      |-> (div_quot_ff[QUOT_W-1] == '0))
      else $error("fixed color with nonzero ramp");

endmodule

`default_nettype wire

// ----- test/tb_scalar_to_rainbow_color.sv -----
`default_nettype none

module tb_scalar_to_rainbow_color;
   import strc_pkg::*;

   localparam int VALUE_W = 16;
   localparam int DATA_W = ((VALUE_W + 7) / 8) * 8;
   localparam int DRAIN_CYCLES = 24;
   localparam int PHASE_ITEMS = 50;
   localparam int RANDOM_PHASES = 13;
   localparam int HOLD_CYCLES = 300;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   // block ports
   logic                    csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = REG_RANGE_LOW;
   logic [VALUE_W-1:0]      csr_wdata = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [DATA_W-1:0]       req_tdata = '0;   // [VALUE_W-1:0] sample_value
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [3*CHAN_W-1:0]     rsp_tdata;        // [7:0] red, [15:8] green, [23:16] blue

   scalar_to_rainbow_color #(
      .VALUE_WIDTH(VALUE_W)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .csr_wen(csr_wen),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   // shadow copy of the configuration registers
   logic signed [VALUE_W-1:0] range_lo_reg = 16'sd0;
   logic signed [VALUE_W-1:0] range_hi_reg = 16'sd256;
   logic                      signed_mode_reg = 1'b0;

   // colors still owed by the block, oldest first
   logic [3*CHAN_W-1:0] color_queue [$];

   int fail_count = 0;
   int samples_sent = 0;
   int colors_checked = 0;
   int settings_used = 0;

   // idling controls for the source and the sink process
   bit src_idle = 1'b0;
   bit sink_idle = 1'b0;
   int hold_request = 0;

   // floor(255*num/den), zero for an empty or negative ramp
   function automatic longint scale255(longint num, longint den);
      if (den <= 0 || num <= 0) return 0;
      return (255 * num) / den;
   endfunction

   // sorted range bounds and quarter points of the current setting
   function automatic void range_points(output longint q[5]);
      longint lo, hi, tmp, d;
      lo = longint'(range_lo_reg);
      hi = longint'(range_hi_reg);
      if (lo > hi) begin
         tmp = lo;
         lo = hi;
         hi = tmp;
      end
      d = hi - lo;
      for (int k = 0; k < 5; k++) q[k] = lo + ((k * d) >>> 2);
   endfunction

   // color expected for one sample under the current setting
   function automatic logic [3*CHAN_W-1:0] rainbow_color(logic [VALUE_W-1:0] sample);
      longint q[5];
      longint v, u, rr, bb;
      logic [CHAN_W-1:0] r, g, b;
      range_points(q);
      v = longint'($signed(sample));
      r = CHAN_ZERO;
      g = CHAN_ZERO;
      b = CHAN_ZERO;
      if (!signed_mode_reg) begin
         if (q[4] == q[0] || v < q[0]) begin
            b = CHAN_MAX;
         end else if (v > q[4]) begin
            r = CHAN_MAX;
         end else if (v <= q[1]) begin
            u = scale255(v - q[0], q[1] - q[0]);
            g = CHAN_W'(u);
            b = CHAN_MAX;
         end else if (v <= q[2]) begin
            u = scale255(v - q[1], q[2] - q[1]);
            g = CHAN_MAX;
            b = CHAN_W'(255 - u);
         end else if (v <= q[3]) begin
            u = scale255(v - q[2], q[3] - q[2]);
            r = CHAN_W'(u);
            g = CHAN_MAX;
         end else begin
            u = scale255(v - q[3], q[4] - q[3]);
            r = CHAN_MAX;
            g = CHAN_W'(255 - u);
         end
      end else if (q[4] == q[0]) begin
         g = CHAN_MAX;
      end else begin
         // clamp, then fade red below zero or blue above
         if (v < q[0]) v = q[0];
         else if (v > q[4]) v = q[4];
         rr = 0;
         bb = 0;
         if (v < 0) rr = scale255(-v, -q[0]);
         else bb = scale255(v, q[4]);
         r = CHAN_W'(rr);
         b = CHAN_W'(bb);
         g = CHAN_W'(255 - rr - bb);
      end
      return {b, g, r};
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // random sample: in range, near a quarter point, or anywhere
   function automatic logic [VALUE_W-1:0] pick_sample();
      longint q[5];
      int r;
      longint v;
      range_points(q);
      r = $urandom_range(0, 9);
      if (r < 2) v = longint'($urandom);
      else if (r < 4) v = q[$urandom_range(0, 4)] + $urandom_range(0, 4) - 2;
      else v = q[0] + $urandom_range(0, int'(q[4] - q[0]));
      return v[VALUE_W-1:0];
   endfunction

   // one register write; leaves csr_wen high for the caller to drop
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         REG_RANGE_LOW:   range_lo_reg = data;
         REG_RANGE_HIGH:  range_hi_reg = data;
         REG_SIGNED_MODE: signed_mode_reg = data[0];
         default: ;
      endcase
   endtask

   // writes all three registers; junk goes into the unused mode bits
   task automatic configure(logic [VALUE_W-1:0] lo, logic [VALUE_W-1:0] hi, logic mode);
      logic [VALUE_W-1:0] mode_word;
      mode_word = VALUE_W'($urandom);
      mode_word[0] = mode;
      write_reg(REG_RANGE_LOW, lo);
      write_reg(REG_RANGE_HIGH, hi);
      write_reg(REG_SIGNED_MODE, mode_word);
      csr_wen <= 1'b0;
      settings_used++;
   endtask

   // offer one sample, wait for acceptance, then maybe pause
   task automatic send_sample(logic [VALUE_W-1:0] sample);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= sample;
      do @(posedge clock); while (!req_tready);
      color_queue.push_back(rainbow_color(sample));
      samples_sent++;
      gap = src_idle ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and let the pipeline empty out
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (color_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // sink: random stalls, plus a long hold on request
   initial begin : sink_proc
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (sink_idle && $urandom_range(0, 4) == 0) stall_left = pick_gap();
         end
      end
   end

   // compare each color word against the oldest expectation
   always @(posedge clock) begin : color_check
      logic [3*CHAN_W-1:0] want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (color_queue.size() == 0) begin
            $error("unexpected color word %h", rsp_tdata);
            fail_count++;
         end else begin
            want = color_queue.pop_front();
            colors_checked++;
            if (rsp_tdata[7:0] !== want[7:0]) begin
               $error("red: expected %0d, got %0d", want[7:0], rsp_tdata[7:0]);
               fail_count++;
            end
            if (rsp_tdata[15:8] !== want[15:8]) begin
               $error("green: expected %0d, got %0d", want[15:8], rsp_tdata[15:8]);
               fail_count++;
            end
            if (rsp_tdata[23:16] !== want[23:16]) begin
               $error("blue: expected %0d, got %0d", want[23:16], rsp_tdata[23:16]);
               fail_count++;
            end
         end
      end
   end

   // reset setting: both range ends, the first quarter point, two mid-segment samples and both sides of the range
   task automatic test_reset_range();
      send_sample(16'sd0);
      send_sample(16'sd64);
      send_sample(16'sd96);
      send_sample(16'sd200);
      send_sample(16'sd256);
      send_sample(-16'sd1);
      send_sample(16'sd257);
      wait_idle();
   endtask

   // widest range, plus a write to the unused index
   task automatic test_full_range();
      write_reg(REG_UNUSED, 16'hFFFF);
      configure(16'h8000, 16'h7FFF, 1'b0);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'h0000);
      wait_idle();
   endtask

   // signed map over a reversed range, samples clamped at both ends
   task automatic test_signed_reversed();
      configure(16'sd512, -16'sd512, 1'b1);
      send_sample(16'h8000);
      send_sample(-16'sd256);
      send_sample(16'sd0);
      send_sample(16'sd300);
      send_sample(16'h7FFF);
      wait_idle();
   endtask

   // empty range in both modes
   task automatic test_empty_range();
      configure(16'sd100, 16'sd100, 1'b0);
      send_sample(16'sd100);
      wait_idle();
      configure(16'sd100, 16'sd100, 1'b1);
      send_sample(16'sd100);
      wait_idle();
   endtask

   // range so narrow that some segments have no width
   task automatic test_zero_segments();
      configure(16'sd0, 16'sd2, 1'b0);
      send_sample(16'sd0);
      send_sample(16'sd1);
      send_sample(16'sd2);
      wait_idle();
   endtask

   // signed map with one range end at zero
   task automatic test_signed_zero_end();
      configure(16'sd0, 16'sd100, 1'b1);
      send_sample(-16'sd5);
      send_sample(16'sd50);
      wait_idle();
      configure(-16'sd100, 16'sd0, 1'b1);
      send_sample(-16'sd50);
      send_sample(16'sd5);
      wait_idle();
   endtask

   // random settings, each followed by a batch of random samples
   task automatic test_random_sweep();
      int r;
      int lo, hi, tmp;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         r = $urandom_range(0, 9);
         case (r)
            0: begin
               lo = $urandom;
               hi = $urandom;
            end
            1: begin
               lo = -32768;
               hi = 32767;
            end
            2: begin
               lo = $urandom;
               hi = lo;
            end
            3: begin
               lo = $urandom_range(0, 65535) - 32768;
               hi = lo + $urandom_range(0, 8);
            end
            default: begin
               lo = $urandom_range(0, 32767) - 16384;
               hi = lo + $urandom_range(1, 4096);
            end
         endcase
         if ($urandom_range(0, 9) < 3) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
         end
         configure(lo[VALUE_W-1:0], hi[VALUE_W-1:0], 1'($urandom_range(0, 1)));
         // some phases run flat out on one or both sides
         src_idle = $urandom_range(0, 3) != 0;
         sink_idle = $urandom_range(0, 3) != 0;
         for (int i = 0; i < PHASE_ITEMS; i++) send_sample(pick_sample());
         wait_idle();
      end
   endtask

   // long sink hold while the source keeps pushing
   task automatic test_backpressure();
      configure(-16'sd1024, 16'sd1024, 1'b0);
      src_idle = 1'b0;
      sink_idle = 1'b0;
      hold_request = HOLD_CYCLES;
      @(posedge clock);
      for (int i = 0; i < 60; i++) send_sample(pick_sample());
      wait_idle();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_range();
      test_full_range();
      test_signed_reversed();
      test_empty_range();
      test_zero_segments();
      test_signed_zero_end();
      test_random_sweep();
      test_backpressure();
      $display("Sent %0d samples under %0d range settings; %0d colors compared.",
               samples_sent, settings_used, colors_checked);
      $display("Both maps, reversed, empty and narrow ranges and a long output hold ran.");
      if (fail_count == 0) begin
         $display("scalar_to_rainbow_color test passed");
      end else begin
         $display("scalar_to_rainbow_color test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("scalar_to_rainbow_color test failed");
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/strc_pkg.sv
rtl/core/scalar_to_rainbow_color.sv
test/tb_scalar_to_rainbow_color.sv
